// File: hw/rtl/cslbp_pkg.sv
// ----------------------------------------------------------------------------
// cslbp_pkg
// Shared constants, types and helpers for the CS-LBP code stream block.
// ----------------------------------------------------------------------------
package cslbp_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int RADIUS     = 3;
  localparam int SPAN       = 2 * RADIUS;

  localparam int PIX_W   = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);     // column index
  localparam int ROW_W   = $clog2(MAX_HEIGHT);    // row index
  localparam int FW_W    = 12;                    // frame_width register
  localparam int FH_W    = 13;                    // frame_height register
  localparam int SLOT_W  = $clog2(SPAN);          // line slot in the store
  localparam int ADDR_W  = SLOT_W + COL_W;
  localparam int DEPTH   = SPAN * MAX_WIDTH;
  localparam int CODE_W  = 4;
  localparam int CFG_W   = FH_W;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Per-pixel bookkeeping carried beside the line store read data.
  typedef struct packed {
    logic [PIX_W-1:0] gray;
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] center_col;
  } pix_meta_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SPAN - 1)) r = '0;
    else                        r = s + SLOT_W'(1);
    return r;
  endfunction

  // Slot of the row RADIUS lines above: (s + RADIUS) mod SPAN.
  function automatic logic [SLOT_W-1:0] slot_mid(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s >= SLOT_W'(RADIUS)) r = s - SLOT_W'(RADIUS);
    else                      r = s + SLOT_W'(RADIUS);
    return r;
  endfunction

endpackage

// File: hw/rtl/cslbp_line_buf.sv
// ----------------------------------------------------------------------------
// cslbp_line_buf
// Raster counters and the 2*R line store: reads two lines, writes the pixel.
// ----------------------------------------------------------------------------
module cslbp_line_buf (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [cslbp_pkg::PIX_W-1:0]    gray,
  input  logic                           frame_start,
  input  logic [cslbp_pkg::FW_W-1:0]     width_eff,
  input  logic [cslbp_pkg::FH_W-1:0]     height_eff,
  output logic [cslbp_pkg::PIX_W-1:0]    top_now,
  output logic [cslbp_pkg::PIX_W-1:0]    mid_now,
  output cslbp_pkg::pix_meta_t           meta
);

  logic [cslbp_pkg::PIX_W-1:0] line_mem [cslbp_pkg::DEPTH];

  logic [cslbp_pkg::ROW_W-1:0]  row_count, row_count_next;
  logic [cslbp_pkg::COL_W-1:0]  col_count, col_count_next;
  logic [cslbp_pkg::SLOT_W-1:0] row_slot, row_slot_next;

  logic [cslbp_pkg::FH_W-1:0]   row_a;
  logic [cslbp_pkg::COL_W-1:0]  col_base;
  logic [cslbp_pkg::SLOT_W-1:0] slot_a;
  logic [cslbp_pkg::ROW_W-1:0]  r;
  logic [cslbp_pkg::COL_W-1:0]  c;
  logic [cslbp_pkg::SLOT_W-1:0] s;
  logic [cslbp_pkg::FW_W-1:0]   c1;
  logic [cslbp_pkg::FH_W-1:0]   r1;
  logic [cslbp_pkg::ADDR_W-1:0] top_addr, mid_addr;

  // Position of this pixel: frame start, then column wrap, then row wrap.
  always_comb begin
    row_a    = frame_start ? '0 : cslbp_pkg::FH_W'(row_count);
    col_base = frame_start ? '0 : col_count;
    slot_a   = frame_start ? '0 : row_slot;
    if (cslbp_pkg::FW_W'(col_base) >= width_eff) begin
      col_base = '0;
      row_a    = row_a + cslbp_pkg::FH_W'(1);
      slot_a   = cslbp_pkg::slot_inc(slot_a);
    end
    if (row_a >= height_eff) begin
      r = '0;
      s = '0;
    end else begin
      r = row_a[cslbp_pkg::ROW_W-1:0];
      s = slot_a;
    end
    c = col_base;

    c1 = cslbp_pkg::FW_W'(c) + cslbp_pkg::FW_W'(1);
    r1 = cslbp_pkg::FH_W'(r) + cslbp_pkg::FH_W'(1);
    row_count_next = r;
    row_slot_next  = s;
    col_count_next = c1[cslbp_pkg::COL_W-1:0];
    if (c1 >= width_eff) begin
      col_count_next = '0;
      if (r1 >= height_eff) begin
        row_count_next = '0;
        row_slot_next  = '0;
      end else begin
        row_count_next = r1[cslbp_pkg::ROW_W-1:0];
        row_slot_next  = cslbp_pkg::slot_inc(s);
      end
    end

    top_addr = {s, c};
    mid_addr = {cslbp_pkg::slot_mid(s), c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      row_slot  <= '0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
      row_slot  <= row_slot_next;
    end
  end

  // Read-before-write: the pixel replaces the oldest line at its column.
  always_ff @(posedge clk) begin
    if (accept) begin
      top_now            <= line_mem[top_addr];
      mid_now            <= line_mem[mid_addr];
      line_mem[top_addr] <= gray;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta.gray       <= gray;
      meta.emit       <= (r >= cslbp_pkg::ROW_W'(cslbp_pkg::SPAN)) &&
                         (c >= cslbp_pkg::COL_W'(cslbp_pkg::SPAN));
      meta.last       <= (cslbp_pkg::FH_W'(r) == height_eff - cslbp_pkg::FH_W'(1)) &&
                         (cslbp_pkg::FW_W'(c) == width_eff - cslbp_pkg::FW_W'(1));
      meta.center_row <= r - cslbp_pkg::ROW_W'(cslbp_pkg::RADIUS);
      meta.center_col <= c - cslbp_pkg::COL_W'(cslbp_pkg::RADIUS);
    end
  end

endmodule

// File: hw/rtl/cs_lbp_code_stream_top.sv
// ----------------------------------------------------------------------------
// cs_lbp_code_stream_top
// Radius-3 center-symmetric LBP: 4-bit code per interior pixel of a frame.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | word
//  --------+-----------------------+----------------------------------------
//  in      | in_valid / in_stall   | gray, frame_start
//  out     | out_valid / out_stall | code, center_row, center_col, frame_end
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
//  One pixel per clock while out_stall does not hold the pipe. A pixel goes
//  from the line store read (synchronous RAM, two reads and one write per
//  pixel) to the compare and tap shift into the output register.
//  rst is synchronous: counters, taps and valids clear; the line store keeps
//  whatever it holds. Sizes return to 2048 x 1024.
//  out_stall holds the output register; the input stalls only while the
//  pipe is full and the waiting pixel has a code to hand over.
// ----------------------------------------------------------------------------
module cs_lbp_code_stream_top (
  input  logic                           clk,
  input  logic                           rst,
  // pixel input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cslbp_pkg::PIX_W-1:0]    gray,
  input  logic                           frame_start,
  // code output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cslbp_pkg::CODE_W-1:0]   code,
  output logic [cslbp_pkg::ROW_W-1:0]    center_row,
  output logic [cslbp_pkg::COL_W-1:0]    center_col,
  output logic                           frame_end,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  cslbp_pkg::cfg_reg_t            cfg_index,
  input  logic [cslbp_pkg::CFG_W-1:0]    cfg_data
);

  logic [cslbp_pkg::FW_W-1:0] frame_width;
  logic [cslbp_pkg::FH_W-1:0] frame_height;
  logic [cslbp_pkg::FW_W-1:0] width_eff;
  logic [cslbp_pkg::FH_W-1:0] height_eff;

  logic                        accept;
  logic                        s1_valid;
  logic                        s1_adv;
  logic                        out_load;
  logic [cslbp_pkg::PIX_W-1:0] top_now, mid_now;
  cslbp_pkg::pix_meta_t        meta;
  logic [cslbp_pkg::CODE_W-1:0] code_next;

  // Window taps: rows i-R (top), i (mid), i+R (bottom); index 0 is newest.
  logic [cslbp_pkg::PIX_W-1:0] tap_top [cslbp_pkg::SPAN];
  logic [cslbp_pkg::PIX_W-1:0] tap_mid [cslbp_pkg::SPAN];
  logic [cslbp_pkg::PIX_W-1:0] tap_bot [cslbp_pkg::SPAN];

  // ---- configuration ------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= cslbp_pkg::FW_W'(cslbp_pkg::MAX_WIDTH);
      frame_height <= cslbp_pkg::FH_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cslbp_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[cslbp_pkg::FW_W-1:0];
        cslbp_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero acts as one; oversize clamps to the store width / max height.
  always_comb begin
    if (frame_width == '0)
      width_eff = cslbp_pkg::FW_W'(1);
    else if (frame_width > cslbp_pkg::FW_W'(cslbp_pkg::MAX_WIDTH))
      width_eff = cslbp_pkg::FW_W'(cslbp_pkg::MAX_WIDTH);
    else
      width_eff = frame_width;
    if (frame_height == '0)
      height_eff = cslbp_pkg::FH_W'(1);
    else if (frame_height > cslbp_pkg::FH_W'(cslbp_pkg::MAX_HEIGHT))
      height_eff = cslbp_pkg::FH_W'(cslbp_pkg::MAX_HEIGHT);
    else
      height_eff = frame_height;
  end

  // ---- handshake ----------------------------------------------------------
  // Output register takes a word when empty or being drained. A pixel with
  // no code leaves stage 1 regardless of the output side.
  assign out_load = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && (out_load || !meta.emit);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  // ---- stage 0: counters and line store ------------------------------------
  cslbp_line_buf u_line_buf (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .gray       (gray),
    .frame_start(frame_start),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .top_now    (top_now),
    .mid_now    (mid_now),
    .meta       (meta)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // ---- stage 1: compare opposite pairs, shift taps -------------------------
  always_comb begin
    code_next[3] = mid_now >= tap_mid[cslbp_pkg::SPAN-1];                    // horizontal
    code_next[2] = top_now >= tap_bot[cslbp_pkg::SPAN-1];                    // anti-diagonal
    code_next[1] = tap_top[cslbp_pkg::RADIUS-1] >= tap_bot[cslbp_pkg::RADIUS-1]; // vertical
    code_next[0] = tap_top[cslbp_pkg::SPAN-1] >= meta.gray;                  // diagonal
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < cslbp_pkg::SPAN; k++) begin
        tap_top[k] <= '0;
        tap_mid[k] <= '0;
        tap_bot[k] <= '0;
      end
    end else if (s1_adv) begin
      for (int k = 1; k < cslbp_pkg::SPAN; k++) begin
        tap_top[k] <= tap_top[k-1];
        tap_mid[k] <= tap_mid[k-1];
        tap_bot[k] <= tap_bot[k-1];
      end
      tap_top[0] <= top_now;
      tap_mid[0] <= mid_now;
      tap_bot[0] <= meta.gray;
    end
  end

  // ---- output register ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid && meta.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      code       <= code_next;
      center_row <= meta.center_row;
      center_col <= meta.center_col;
      frame_end  <= meta.last;
    end
  end

  // ---- assertions ---------------------------------------------------------
  // Input only stalls behind a held pixel that still owes a code.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && meta.emit && out_valid && out_stall))
    else $error("input stalled without a blocked code");

  // An accepted pixel is always held in stage 1 on the next cycle.
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel lost before stage 1");

  // The frame's last code belongs to the last interior column.
  a_last_col: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |->
      ((cslbp_pkg::FW_W'(center_col) + cslbp_pkg::FW_W'(cslbp_pkg::RADIUS + 1)) == width_eff))
    else $error("frame_end on a column other than the last interior one");

endmodule

// File: test/tb_cs_lbp_code_stream_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cs_lbp_code_stream_top
// Self-checking bench for the radius-3 CS-LBP code stream block.
// A local predictor keeps its own line store, counters and window taps and
// works out the code word for every taken pixel that closes a window. Directed
// frames cover the size extremes and special cases. Random frames follow.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_cs_lbp_code_stream_top;

  localparam int QUIET_LIMIT = 5000;  // cycles with no handshake on any channel
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int SHOW_MAX    = 20;    // mismatch lines printed at most

  typedef struct packed {
    logic [cslbp_pkg::PIX_W-1:0] gray;
    logic                        sof;
  } pixel_t;

  typedef struct packed {
    logic [cslbp_pkg::CODE_W-1:0] code;
    logic [cslbp_pkg::ROW_W-1:0]  row;
    logic [cslbp_pkg::COL_W-1:0]  col;
    logic                         last;
  } lbp_word_t;

  typedef enum {GAPS_NONE, GAPS_SEND, GAPS_RECV, GAPS_BOTH} gap_mode_t;

  // DUT ports; every input is known from time zero
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [cslbp_pkg::PIX_W-1:0]   gray = '0;
  logic                          frame_start = 1'b0;
  logic                          out_valid;
  logic                          out_stall;
  logic [cslbp_pkg::CODE_W-1:0]  code;
  logic [cslbp_pkg::ROW_W-1:0]   center_row;
  logic [cslbp_pkg::COL_W-1:0]   center_col;
  logic                          frame_end;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  cslbp_pkg::cfg_reg_t           cfg_index = cslbp_pkg::REG_FRAME_WIDTH;
  logic [cslbp_pkg::CFG_W-1:0]   cfg_data = '0;

  // stimulus and checking state
  pixel_t      pixel_backlog[$];   // words waiting for the driver
  lbp_word_t   pending_codes[$];   // predicted code words, oldest first
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        rand_stall = 1'b0;
  logic        pressure_arm = 1'b0;
  logic        hold_used = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;
  int unsigned shown = 0;
  int unsigned px_pushed = 0;
  int unsigned px_accepted = 0;
  int unsigned codes_seen = 0;
  int unsigned ends_seen = 0;
  int unsigned reg_writes = 0;

  // predictor state
  logic [cslbp_pkg::PIX_W-1:0] line_mem [cslbp_pkg::DEPTH];
  logic [cslbp_pkg::PIX_W-1:0] tap_top [cslbp_pkg::SPAN];  // row i-R
  logic [cslbp_pkg::PIX_W-1:0] tap_mid [cslbp_pkg::SPAN];  // row i
  logic [cslbp_pkg::PIX_W-1:0] tap_bot [cslbp_pkg::SPAN];  // row i+R
  logic [cslbp_pkg::FW_W-1:0]  cur_width;
  logic [cslbp_pkg::FH_W-1:0]  cur_height;
  int unsigned                 pos_row;
  int unsigned                 pos_col;

  cs_lbp_code_stream_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .gray        (gray),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code        (code),
    .center_row  (center_row),
    .center_col  (center_col),
    .frame_end   (frame_end),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the predictor by one pixel word. Returns 1 when the pixel closes
  // the window of an interior centre; the code word then lands in w.
  function automatic bit lbp_advance(input pixel_t px, output lbp_word_t w);
    int unsigned wdt, hgt, r, c, top_a, mid_a;
    logic [cslbp_pkg::PIX_W-1:0] top_now, mid_now;
    bit hit;
    wdt = (cur_width == 0) ? 1 :
          ((cur_width > cslbp_pkg::MAX_WIDTH) ? cslbp_pkg::MAX_WIDTH : cur_width);
    hgt = (cur_height == 0) ? 1 :
          ((cur_height > cslbp_pkg::MAX_HEIGHT) ? cslbp_pkg::MAX_HEIGHT : cur_height);
    if (px.sof) begin
      pos_row = 0;
      pos_col = 0;
    end
    // sizes may have shrunk under the counters
    if (pos_col >= wdt) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= hgt) pos_row = 0;
    r = pos_row;
    c = pos_col;
    top_a = (r % cslbp_pkg::SPAN) * cslbp_pkg::MAX_WIDTH + c;
    mid_a = ((r + cslbp_pkg::RADIUS) % cslbp_pkg::SPAN) * cslbp_pkg::MAX_WIDTH + c;
    top_now = line_mem[top_a];
    mid_now = line_mem[mid_a];
    hit = (r >= cslbp_pkg::SPAN) && (c >= cslbp_pkg::SPAN);
    w = '0;
    if (hit) begin
      w.code = {mid_now >= tap_mid[cslbp_pkg::SPAN-1],                        // horizontal
                top_now >= tap_bot[cslbp_pkg::SPAN-1],                        // anti-diagonal
                tap_top[cslbp_pkg::RADIUS-1] >= tap_bot[cslbp_pkg::RADIUS-1], // vertical
                tap_top[cslbp_pkg::SPAN-1] >= px.gray};                       // diagonal
      w.row  = cslbp_pkg::ROW_W'(r - cslbp_pkg::RADIUS);
      w.col  = cslbp_pkg::COL_W'(c - cslbp_pkg::RADIUS);
      w.last = (r == hgt - 1) && (c == wdt - 1);
    end
    line_mem[top_a] = px.gray;
    for (int k = cslbp_pkg::SPAN - 1; k > 0; k--) begin
      tap_top[k] = tap_top[k-1];
      tap_mid[k] = tap_mid[k-1];
      tap_bot[k] = tap_bot[k-1];
    end
    tap_top[0] = top_now;
    tap_mid[0] = mid_now;
    tap_bot[0] = px.gray;
    pos_col = c + 1;
    if (pos_col >= wdt) begin
      pos_col = 0;
      pos_row = r + 1;
      if (pos_row >= hgt) pos_row = 0;
    end
    return hit;
  endfunction

  // Gray values lean on 0, 255 and mid scale so that equal pairs show up.
  function automatic logic [cslbp_pkg::PIX_W-1:0] pick_gray();
    logic [cslbp_pkg::PIX_W-1:0] g;
    case ($urandom_range(4))
      0:       g = '0;
      1:       g = '1;
      2:       g = 8'h80;
      default: g = cslbp_pkg::PIX_W'($urandom);
    endcase
    return g;
  endfunction

  task automatic push_pixels(input int unsigned n, input bit sof_first,
                             input int unsigned sof_pct);
    pixel_t px;
    for (int unsigned i = 0; i < n; i++) begin
      px.gray = pick_gray();
      px.sof  = (i == 0) ? sof_first : ($urandom_range(99) < sof_pct);
      pixel_backlog.insert(pixel_backlog.size(), px);
    end
    px_pushed += n;
  endtask

  // Block idle: nothing queued, nothing offered, nothing owed, plus a wait
  // for a pixel that makes no code to clear the pipe.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || in_valid || pending_codes.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input cslbp_pkg::cfg_reg_t idx,
                           input logic [cslbp_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == cslbp_pkg::REG_FRAME_WIDTH) cur_width = val[cslbp_pkg::FW_W-1:0];
    else                                   cur_height = val[cslbp_pkg::FH_W-1:0];
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic set_size(input logic [cslbp_pkg::CFG_W-1:0] wdt,
                          input logic [cslbp_pkg::CFG_W-1:0] hgt);
    cfg_write(cslbp_pkg::REG_FRAME_WIDTH, wdt);
    cfg_write(cslbp_pkg::REG_FRAME_HEIGHT, hgt);
  endtask

  task automatic set_gaps(input gap_mode_t m);
    case (m)
      GAPS_NONE: begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      GAPS_SEND: begin
        send_gap_pct = 50;
        recv_stall_pct = 0;
      end
      GAPS_RECV: begin
        send_gap_pct = 0;
        recv_stall_pct = 50;
      end
      default: begin
        send_gap_pct = 29;
        recv_stall_pct = 29;
      end
    endcase
  endtask

  task automatic flag(input string what, input int unsigned exp_v, input int unsigned act_v);
    errors++;
    if (shown < SHOW_MAX) begin
      shown++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    end
  endtask

  // Driver: a word stays on the port until taken; the predictor runs on
  // every word at the edge where it is taken.
  always @(posedge clk) begin : drv
    pixel_t    nxt;
    lbp_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        px_accepted++;
        if (lbp_advance(pixel_t'({gray, frame_start}), w))
          pending_codes.insert(pending_codes.size(), w);
      end
      if (!in_valid || !in_stall) begin
        if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = pixel_backlog.pop_front();
          in_valid    <= 1'b1;
          gray        <= nxt.gray;
          frame_start <= nxt.sof;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every code word taken is checked against the oldest prediction.
  always @(posedge clk) begin : mon
    lbp_word_t want;
    if (rst) begin
      rand_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        codes_seen++;
        if (frame_end) ends_seen++;
        if (pending_codes.size() == 0) begin
          flag("unexpected code word, code", 0, code);
        end else begin
          want = pending_codes.pop_front();
          if (code !== want.code)       flag("code", want.code, code);
          if (center_row !== want.row)  flag("center_row", want.row, center_row);
          if (center_col !== want.col)  flag("center_col", want.col, center_col);
          if (frame_end !== want.last)  flag("frame_end", want.last, frame_end);
        end
      end
      rand_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // One long hold-off on the output side, counted here, once armed.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (pressure_arm && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  assign out_stall = rand_stall | (hold_left != 0);

  // Watchdog: too long with no handshake anywhere means the block is stuck.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles at %0t", quiet_cycles, $time);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned fw, fh, n, px_mark, code_mark, ph;

    // predictor reset: sizes back to 2048 x 1024, taps and counters clear
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (tap_top[i]) begin
      tap_top[i] = '0;
      tap_mid[i] = '0;
      tap_bot[i] = '0;
    end
    cur_width  = cslbp_pkg::FW_W'(2048);
    cur_height = cslbp_pkg::FH_W'(1024);
    pos_row = 0;
    pos_col = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset sizes: a short run on row 0, no centre yet.
    set_gaps(GAPS_NONE);
    push_pixels(8, 1'b1, 0);
    wait_quiet();

    // 12 x 6 writes columns 0..11 of every line slot; no frame that makes
    // codes later is wider, so no code depends on an unwritten entry.
    // Height 6 gives no codes.
    set_size(12, 6);
    push_pixels(72, 1'b1, 0);
    wait_quiet();

    // Smallest frame that has a centre, twice; the second relies on the
    // wrap past the last pixel instead of frame_start.
    set_size(7, 7);
    push_pixels(2 * 49, 1'b1, 0);
    wait_quiet();

    // frame_start in the middle of a frame
    set_gaps(GAPS_SEND);
    push_pixels(10, 1'b0, 0);
    push_pixels(49, 1'b1, 0);
    wait_quiet();

    // zero sizes act as 1; widths up to 6 give no codes at all
    set_size(0, 0);
    push_pixels(8, 1'b0, 0);
    wait_quiet();
    set_size(6, 7);
    push_pixels(21, 1'b1, 0);
    wait_quiet();

    // resize mid-frame: shrink, then grow
    set_gaps(GAPS_RECV);
    set_size(12, 10);
    push_pixels(30, 1'b1, 0);
    wait_quiet();
    set_size(8, 8);
    push_pixels(20, 1'b0, 0);
    wait_quiet();
    set_size(12, 8);
    push_pixels(40, 1'b0, 0);
    wait_quiet();

    // receiver holds off for a long stretch while pixels keep coming
    set_gaps(GAPS_NONE);
    set_size(8, 8);
    pressure_arm = 1'b1;
    push_pixels(64, 1'b1, 0);
    wait_quiet();

    // all-ones registers clamp to 2048 x 4096
    set_gaps(GAPS_BOTH);
    set_size(13'h1FFF, 13'h1FFF);
    push_pixels(16, 1'b1, 0);
    wait_quiet();
    set_size(7, 13'h1FFF);
    push_pixels(49, 1'b1, 0);
    wait_quiet();

    // random frames: whole frames with random content plus a short tail,
    // stray frame_starts and the odd missing one
    px_mark   = px_pushed;
    code_mark = codes_seen;
    ph = 0;
    while ((px_pushed - px_mark < 60 || codes_seen - code_mark < 4) && ph < 20) begin
      set_gaps(gap_mode_t'(ph % 4));
      fw = ($urandom_range(5) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 12);
      fh = ($urandom_range(5) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 8);
      set_size(cslbp_pkg::CFG_W'(fw), cslbp_pkg::CFG_W'(fh));
      n = fw * fh + $urandom_range(0, fw);
      push_pixels(n, $urandom_range(9) != 0, 2);
      wait_quiet();
      ph++;
    end

    if (pending_codes.size() != 0) begin
      errors += pending_codes.size();
      $display("%0t: %0d predicted code words never arrived", $time, pending_codes.size());
    end
    $display("covered: reset and clamped sizes, degenerate frames, resizes, restarts,");
    $display("  wraps; %0d pixels, %0d codes, %0d frame ends, %0d reg writes, %0d bad",
             px_accepted, codes_seen, ends_seen, reg_writes, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/cslbp_pkg.sv
hw/rtl/cslbp_line_buf.sv
hw/rtl/cs_lbp_code_stream_top.sv
test/tb_cs_lbp_code_stream_top.sv
